[sv/hss_pkg.sv]
// Shared constants, codes and helpers for the hyperbox split selector.
package hss_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int DIMS       = 8;
  localparam int CW         = 32;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int ROW_W      = DIMS * CW;
  localparam int DIM_W      = 3;
  localparam int NUM_W      = CW + 2;
  localparam int DEN_W      = CW + 1;
  localparam int PROD_W     = NUM_W + DEN_W;

  localparam logic [1:0] FUNC_MIN   = 2'd0;
  localparam logic [1:0] FUNC_MAX   = 2'd1;
  localparam logic [1:0] FUNC_POINT = 2'd2;

  localparam logic [1:0] ST_MEDIAN = 2'd0;
  localparam logic [1:0] ST_COUNT  = 2'd1;
  localparam logic [1:0] ST_FEW    = 2'd2;
  localparam logic [1:0] ST_NONE   = 2'd3;

  // Pick one dimension's word out of a stored coordinate row.
  function automatic logic signed [CW-1:0] lane(input logic [ROW_W-1:0] row,
                                                input logic [DIM_W-1:0] d);
    lane = row[d*CW +: CW];
  endfunction

endpackage

[sv/hss_mul.sv]
// Shift-add multiplier shared by the median metric comparison.
module hss_mul (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [hss_pkg::NUM_W-1:0]         a,
  input  logic [hss_pkg::DEN_W-1:0]         b,
  output logic                              done,
  output logic [hss_pkg::PROD_W-1:0]        prod
);

  logic [hss_pkg::PROD_W-1:0] mc_r;
  logic [hss_pkg::PROD_W-1:0] acc_r;
  logic [hss_pkg::DEN_W-1:0]  mp_r;
  logic [5:0]                 k_r;
  logic                       busy_r;
  logic                       done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        mc_r   <= {{(hss_pkg::PROD_W-hss_pkg::NUM_W){1'b0}}, a};
        mp_r   <= b;
        acc_r  <= '0;
        k_r    <= 6'(hss_pkg::DEN_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        // add the shifted multiplicand for each set multiplier bit
        if (mp_r[0]) acc_r <= acc_r + mc_r;
        mc_r <= mc_r << 1;
        mp_r <= mp_r >> 1;
        k_r  <= k_r - 6'd1;
        if (k_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

[sv/hyperbox_split_selector.sv]
// Top level of the hyperbox split selector: storage, sequencer and result port.
//
// Box minimum and maximum loads and ordinary points are taken one request per
// cycle while idle; each point row (all eight coordinates) and its score go
// into on-chip memories of 1024 entries. The point flagged last starts the
// split search and the block holds in_ready low until the result is
// registered. The search streams the score memory once to find the lowest and
// highest score, then once per candidate to rank it (the dominant cost), then
// streams the coordinate memory once per active dimension to count points
// below the candidate value. Median metrics are compared by
// cross-multiplication on one shift-add multiplier, two products per
// comparison. The fallback pass streams the coordinate memory once more per
// dimension. A new request is taken while a result still waits on the
// output. Points beyond 1024 are dropped but their last flag still counts.
module hyperbox_split_selector (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_func,
  input  logic signed [31:0]  in_coord_0,
  input  logic signed [31:0]  in_coord_1,
  input  logic signed [31:0]  in_coord_2,
  input  logic signed [31:0]  in_coord_3,
  input  logic signed [31:0]  in_coord_4,
  input  logic signed [31:0]  in_coord_5,
  input  logic signed [31:0]  in_coord_6,
  input  logic signed [31:0]  in_coord_7,
  input  logic signed [31:0]  in_score,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic [2:0]          out_split_dim,
  output logic signed [31:0]  out_split_value,
  output logic [10:0]         out_count_lower,
  output logic [10:0]         out_count_upper
);

  localparam int CW    = hss_pkg::CW;
  localparam int IW    = hss_pkg::IDX_W;
  localparam int NW    = hss_pkg::CNT_W;
  localparam int RW    = hss_pkg::ROW_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MM    = 4'd1;
  localparam logic [3:0] S_RK_I  = 4'd2;
  localparam logic [3:0] S_RK_L  = 4'd3;
  localparam logic [3:0] S_RK_J  = 4'd4;
  localparam logic [3:0] S_MID_R = 4'd5;
  localparam logic [3:0] S_MID_L = 4'd6;
  localparam logic [3:0] S_CNT   = 4'd7;
  localparam logic [3:0] S_EVAL  = 4'd8;
  localparam logic [3:0] S_MUL1  = 4'd9;
  localparam logic [3:0] S_MUL2  = 4'd10;
  localparam logic [3:0] S_NEXT  = 4'd11;
  localparam logic [3:0] S_FB_R  = 4'd12;
  localparam logic [3:0] S_FB_L1 = 4'd13;
  localparam logic [3:0] S_FB_L2 = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  // point storage
  logic [RW-1:0]        cr_mem [hss_pkg::MAX_POINTS];
  logic signed [CW-1:0] sc_mem [hss_pkg::MAX_POINTS];
  logic [RW-1:0]        cr_q_r;
  logic signed [CW-1:0] sc_q_r;
  logic [IW-1:0]        cr_addr;
  logic [IW-1:0]        sc_addr;

  logic [3:0]           state_r;
  logic [3:0]           adims_r;
  logic signed [CW-1:0] bmin_r [hss_pkg::DIMS];
  logic signed [CW-1:0] bmax_r [hss_pkg::DIMS];
  logic [NW-1:0]        pc_r;
  logic [NW-1:0]        n_r;
  logic [3:0]           nd_r;
  logic                 few_r;

  // streaming read pipeline
  logic [NW-1:0]        cnt_r;
  logic                 pv_r;
  logic [IW-1:0]        pj_r;
  logic [NW-1:0]        acc_r;

  logic [IW-1:0]        i_r;
  logic signed [CW-1:0] si_r;
  logic [IW-1:0]        lo_i_r, hi_i_r, mid_i_r;
  logic signed [CW-1:0] lo_s_r, hi_s_r;

  logic [RW-1:0]        row_r, rowb_r;
  logic [2:0]           d_r;
  logic signed [CW-1:0] x_r;
  logic                 fb_r, found_r;
  logic [2:0]           bdim_r;
  logic signed [CW-1:0] bval_r;
  logic [NW-1:0]        blow_r;
  logic [hss_pkg::NUM_W-1:0]  bn_r, num_r;
  logic [hss_pkg::DEN_W-1:0]  bd_r, den_r;
  logic [NW:0]                bm_r;
  logic [hss_pkg::PROD_W-1:0] p1_r;

  logic                 out_valid_r;
  logic [1:0]           o_status_r;
  logic [2:0]           o_dim_r;
  logic signed [CW-1:0] o_val_r;
  logic [NW-1:0]        o_lo_r, o_up_r;

  logic                 in_fire;
  logic [RW-1:0]        in_row;
  logic                 str_run, str_more, str_end;
  logic [NW-1:0]        pc_inc;

  logic signed [CW+2:0] num_s;
  logic signed [CW:0]   den_s;
  logic [hss_pkg::NUM_W-1:0] num_c;
  logic [hss_pkg::DEN_W-1:0] den_c;
  logic                 cvalid;
  logic signed [NW+1:0] bal_s;
  logic [NW:0]          bal_c;
  logic [2:0]           d_inc;
  logic                 d_more;
  logic signed [CW:0]   half_sum;
  logic signed [CW:0]   half_sum0;

  logic                 mul_start, mul_done;
  logic [hss_pkg::NUM_W-1:0]  mul_a;
  logic [hss_pkg::DEN_W-1:0]  mul_b;
  logic [hss_pkg::PROD_W-1:0] mul_p;

  hss_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign in_row   = {in_coord_7, in_coord_6, in_coord_5, in_coord_4,
                     in_coord_3, in_coord_2, in_coord_1, in_coord_0};
  assign pc_inc   = (pc_r < NW'(hss_pkg::MAX_POINTS)) ? pc_r + NW'(1) : pc_r;

  // issue one read per cycle until all n entries have gone out
  assign str_run  = (state_r == S_MM) || (state_r == S_RK_J) || (state_r == S_CNT);
  assign str_more = (cnt_r < n_r);
  assign str_end  = !str_more && !pv_r;

  always_comb begin
    sc_addr = cnt_r[IW-1:0];
    cr_addr = cnt_r[IW-1:0];
    if (state_r == S_RK_I)  sc_addr = i_r;
    if (state_r == S_MID_R) cr_addr = mid_i_r;
    if (state_r == S_FB_R)  cr_addr = lo_i_r;
    if (state_r == S_FB_L1) cr_addr = hi_i_r;
  end

  // candidate metrics for the current dimension
  always_comb begin
    num_s  = {{2{x_r[CW-1]}}, x_r, 1'b0}
           - ((CW+3)'(bmax_r[d_r]) + (CW+3)'(bmin_r[d_r]));
    num_c  = num_s[CW+2] ? hss_pkg::NUM_W'(-num_s) : hss_pkg::NUM_W'(num_s);
    den_s  = (CW+1)'(bmax_r[d_r]) - (CW+1)'(bmin_r[d_r]);
    den_c  = den_s[CW] ? '0 : hss_pkg::DEN_W'(den_s);
    cvalid = (acc_r != '0) && (acc_r != n_r);
    bal_s  = (NW+2)'({acc_r, 1'b0}) - (NW+2)'(n_r);
    bal_c  = bal_s[NW+1] ? (NW+1)'(-bal_s) : (NW+1)'(bal_s);
    d_inc  = d_r + 3'd1;
    d_more = ({1'b0, d_inc} < nd_r) && (d_r != 3'd7);
    half_sum  = (CW+1)'(hss_pkg::lane(row_r, d_inc))
              + (CW+1)'(hss_pkg::lane(rowb_r, d_inc));
    half_sum0 = (CW+1)'(hss_pkg::lane(row_r, 3'd0))
              + (CW+1)'(hss_pkg::lane(cr_q_r, 3'd0));
  end

  always_comb begin
    mul_start = 1'b0;
    mul_a     = num_c;
    mul_b     = bd_r;
    if (state_r == S_EVAL && !fb_r && cvalid && found_r &&
        den_c != '0 && bd_r != '0) begin
      mul_start = 1'b1;
    end
    if (state_r == S_MUL1 && mul_done) begin
      mul_start = 1'b1;
      mul_a     = bn_r;
      mul_b     = den_r;
    end
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (in_fire && in_func == hss_pkg::FUNC_POINT &&
        pc_r < NW'(hss_pkg::MAX_POINTS)) begin
      cr_mem[pc_r[IW-1:0]] <= in_row;
      sc_mem[pc_r[IW-1:0]] <= in_score;
    end
    cr_q_r <= cr_mem[cr_addr];
    sc_q_r <= sc_mem[sc_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      adims_r     <= 4'd8;
      pc_r        <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      fb_r        <= 1'b0;
      few_r       <= 1'b0;
      for (int k = 0; k < hss_pkg::DIMS; k++) begin
        bmin_r[k] <= '0;
        bmax_r[k] <= '0;
      end
    end else begin
      if (cfg_we) adims_r <= cfg_wdata;
      // drop the taken result; a fresh one is loaded in S_DONE
      if (out_ready && state_r != S_DONE) out_valid_r <= 1'b0;

      // streaming states advance the read pipeline every cycle; all other
      // states hold it cleared for the next pass
      if (str_run) begin
        if (str_more) cnt_r <= cnt_r + NW'(1);
        pv_r <= str_more;
        pj_r <= cnt_r[IW-1:0];
      end else begin
        cnt_r <= '0;
        pv_r  <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_func == hss_pkg::FUNC_MIN) begin
              for (int k = 0; k < hss_pkg::DIMS; k++) bmin_r[k] <= in_row[k*CW +: CW];
            end else if (in_func == hss_pkg::FUNC_MAX) begin
              for (int k = 0; k < hss_pkg::DIMS; k++) bmax_r[k] <= in_row[k*CW +: CW];
            end else if (in_func == hss_pkg::FUNC_POINT) begin
              pc_r <= in_last ? '0 : pc_inc;
              if (in_last) begin
                n_r     <= pc_inc;
                nd_r    <= (adims_r > 4'd8) ? 4'd8 : adims_r;
                few_r   <= (pc_inc < NW'(2));
                found_r <= 1'b0;
                fb_r    <= 1'b0;
                state_r <= (pc_inc < NW'(2)) ? S_DONE : S_MM;
              end
            end
          end
        end
        S_MM: begin
          // first lowest score and last highest score
          if (pv_r) begin
            if (pj_r == '0 || sc_q_r < lo_s_r) begin
              lo_s_r <= sc_q_r;
              lo_i_r <= pj_r;
            end
            if (pj_r == '0 || sc_q_r >= hi_s_r) begin
              hi_s_r <= sc_q_r;
              hi_i_r <= pj_r;
            end
          end
          if (str_end) begin
            i_r     <= '0;
            state_r <= S_RK_I;
          end
        end
        S_RK_I: begin
          state_r <= S_RK_L;
        end
        S_RK_L: begin
          si_r    <= sc_q_r;
          acc_r   <= '0;
          state_r <= S_RK_J;
        end
        S_RK_J: begin
          // stable rank of candidate i
          if (pv_r && (sc_q_r < si_r || (sc_q_r == si_r && pj_r < i_r))) begin
            acc_r <= acc_r + NW'(1);
          end
          if (str_end) begin
            if (acc_r == (n_r >> 1)) begin
              mid_i_r <= i_r;
              state_r <= S_MID_R;
            end else begin
              i_r     <= i_r + IW'(1);
              state_r <= S_RK_I;
            end
          end
        end
        S_MID_R: begin
          state_r <= S_MID_L;
        end
        S_MID_L: begin
          row_r <= cr_q_r;
          d_r   <= '0;
          x_r   <= hss_pkg::lane(cr_q_r, 3'd0);
          acc_r <= '0;
          state_r <= (nd_r == 4'd0) ? S_FB_R : S_CNT;
        end
        S_CNT: begin
          if (pv_r && hss_pkg::lane(cr_q_r, d_r) < x_r) acc_r <= acc_r + NW'(1);
          if (str_end) state_r <= S_EVAL;
        end
        S_EVAL: begin
          if (cvalid) begin
            if (fb_r) begin
              if (!found_r || bal_c < bm_r) begin
                found_r <= 1'b1;
                bdim_r  <= d_r;
                bval_r  <= x_r;
                bm_r    <= bal_c;
                blow_r  <= acc_r;
              end
            end else if (!found_r || (den_c != '0 && bd_r == '0)) begin
              found_r <= 1'b1;
              bdim_r  <= d_r;
              bval_r  <= x_r;
              bn_r    <= num_c;
              bd_r    <= den_c;
              blow_r  <= acc_r;
            end
          end
          if (cvalid && !fb_r && found_r && den_c != '0 && bd_r != '0) begin
            // compare num/den against the best by cross products
            num_r   <= num_c;
            den_r   <= den_c;
            state_r <= S_MUL1;
          end else begin
            state_r <= S_NEXT;
          end
        end
        S_MUL1: begin
          if (mul_done) begin
            p1_r    <= mul_p;
            state_r <= S_MUL2;
          end
        end
        S_MUL2: begin
          if (mul_done) begin
            if (p1_r < mul_p) begin
              bdim_r <= d_r;
              bval_r <= x_r;
              bn_r   <= num_r;
              bd_r   <= den_r;
              blow_r <= acc_r;
            end
            state_r <= S_NEXT;
          end
        end
        S_NEXT: begin
          acc_r <= '0;
          if (d_more) begin
            d_r     <= d_inc;
            x_r     <= fb_r ? half_sum[CW:1] : hss_pkg::lane(row_r, d_inc);
            state_r <= S_CNT;
          end else if (!fb_r && !found_r) begin
            state_r <= S_FB_R;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_FB_R: begin
          state_r <= S_FB_L1;
        end
        S_FB_L1: begin
          row_r   <= cr_q_r;
          state_r <= S_FB_L2;
        end
        S_FB_L2: begin
          rowb_r  <= cr_q_r;
          fb_r    <= 1'b1;
          d_r     <= '0;
          x_r     <= half_sum0[CW:1];
          acc_r   <= '0;
          state_r <= (nd_r == 4'd0) ? S_DONE : S_CNT;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            if (few_r) begin
              o_status_r <= hss_pkg::ST_FEW;
            end else if (!found_r) begin
              o_status_r <= hss_pkg::ST_NONE;
            end else begin
              o_status_r <= fb_r ? hss_pkg::ST_COUNT : hss_pkg::ST_MEDIAN;
            end
            if (few_r || !found_r) begin
              o_dim_r <= '0;
              o_val_r <= '0;
              o_lo_r  <= '0;
              o_up_r  <= '0;
            end else begin
              o_dim_r <= bdim_r;
              o_val_r <= bval_r;
              o_lo_r  <= blow_r;
              o_up_r  <= n_r - blow_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = o_status_r;
  assign out_split_dim   = o_dim_r;
  assign out_split_value = o_val_r;
  assign out_count_lower = o_lo_r;
  assign out_count_upper = o_up_r;

endmodule
